// ----- rtl/ffba_pkg.sv -----
// ffba_pkg: shared constants, codes and types of the first-fit block allocator
// no dependencies; used by the channel interfaces and the top level

package ffba_pkg;

  localparam int unsigned MAX_BLOCKS   = 256;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned MAX_REQUEST  = 100000000;
  localparam int unsigned SIZE_W       = $clog2(MAX_REQUEST + 1);
  localparam int unsigned META_W       = 14;
  localparam int unsigned ADDR_W       = 32;
  localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'd1048576;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_CALLOC  = 3'd1,
    ACT_FREE    = 3'd2,
    ACT_REALLOC = 3'd3,
    ACT_QUERY   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_SIZE   = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_UNKNOWN    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_FIND,
    S_FIT,
    S_APPEND,
    S_RELEASE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

endpackage

// ----- rtl/ffba_if.sv -----
// ffba_if: valid/ready channel interfaces of the allocator (request, response, config)
// depends on ffba_pkg for field widths

interface ffba_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    action;
  logic [ffba_pkg::ADDR_W-1:0]   req_size;
  logic [ffba_pkg::ADDR_W-1:0]   elem_count;
  logic [ffba_pkg::ADDR_W-1:0]   address;

  modport source (output valid, action, req_size, elem_count, address, input ready);
  modport sink   (input valid, action, req_size, elem_count, address, output ready);
endinterface

interface ffba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffba_pkg::ADDR_W-1:0]   result_address;
  logic [2:0]                    status;
  logic [ffba_pkg::CNT_W-1:0]    free_blocks;
  logic [ffba_pkg::ADDR_W-1:0]   free_bytes;
  logic [ffba_pkg::CNT_W-1:0]    total_blocks;
  logic [ffba_pkg::ADDR_W-1:0]   total_bytes;
  logic [ffba_pkg::META_W-1:0]   meta_bytes;

  modport source (output valid, result_address, status, free_blocks, free_bytes,
                  total_blocks, total_bytes, meta_bytes, input ready);
  modport sink   (input valid, result_address, status, free_blocks, free_bytes,
                  total_blocks, total_bytes, meta_bytes, output ready);
endinterface

interface ffba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffba_pkg::ADDR_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/first_fit_block_allocator.sv -----
// first_fit_block_allocator: first-fit heap block table without splitting
// depends on ffba_pkg and the channel interfaces in ffba_if.sv
//
//   channel | dir | beat carries                                    | handshake
//   --------+-----+-------------------------------------------------+-----------
//   cfg     | in  | heap_limit write data                           | valid/ready
//   req     | in  | action, req_size, elem_count, address           | valid/ready
//   rsp     | out | result_address, status, block and byte stats    | valid/ready
//
// one request at a time; query and null free do not search the table, allocate, calloc
//   and free search it at most once, and a realloc growing a block at most twice
// the single table read port sets the cost: search and address match read one entry a cycle
// reset (rst, synchronous) empties the table through the entry count; entries are never cleared
// a stalled rsp holds the finished request behind the output register; cfg is always ready

module first_fit_block_allocator (
  input  logic         clk,
  input  logic         rst,
  ffba_cfg_if.sink     cfg,
  ffba_req_if.sink     req,
  ffba_rsp_if.source   rsp
);
  import ffba_pkg::*;

  // block table, one read and one write port
  entry_t mem [MAX_BLOCKS];
  entry_t rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;

  // control state
  state_t state, state_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [ADDR_W:0]   break_offset, break_offset_next;
  logic [CNT_W-1:0]  free_count, free_count_next;
  logic [ADDR_W-1:0] free_sum, free_sum_next;
  logic [ADDR_W-1:0] size_sum, size_sum_next;
  logic [ADDR_W-1:0] heap_limit;
  logic              pend, pend_next;
  logic              rsp_valid, rsp_valid_next;

  // per-request working registers
  logic [2:0]        act, act_next;
  logic [ADDR_W-1:0] req_q, req_q_next;
  logic [ADDR_W-1:0] cnt_q, cnt_q_next;
  logic [ADDR_W-1:0] addr_q, addr_q_next;
  logic [2*ADDR_W-1:0] prod_q, prod_q_next;
  logic [SIZE_W-1:0] sz, sz_next;
  logic [CNT_W-1:0]  issue_idx, issue_idx_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic              have_old, have_old_next;
  logic [IDX_W-1:0]  old_idx, old_idx_next;
  entry_t            old_entry, old_entry_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  status_t           status_q, status_q_next;

  // response register
  logic [ADDR_W-1:0] o_addr, o_addr_next;
  status_t           o_status, o_status_next;
  logic [CNT_W-1:0]  o_free_blocks, o_free_blocks_next;
  logic [ADDR_W-1:0] o_free_bytes, o_free_bytes_next;
  logic [CNT_W-1:0]  o_total_blocks, o_total_blocks_next;
  logic [ADDR_W-1:0] o_total_bytes, o_total_bytes_next;
  logic [META_W-1:0] o_meta, o_meta_next;

  // shared search unit and helpers
  logic [2*ADDR_W-1:0] size_src;
  logic                size_ok;
  logic                scan_issue;
  logic                hit_fit;
  logic                hit_find;
  logic                scan_hit;
  logic                scan_miss;
  logic [ADDR_W+1:0]   end_offset;
  logic [ADDR_W-1:0]   rd_payload;
  logic [ADDR_W-1:0]   brk_payload;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid          = rsp_valid;
  assign rsp.result_address = o_addr;
  assign rsp.status         = o_status;
  assign rsp.free_blocks    = o_free_blocks;
  assign rsp.free_bytes     = o_free_bytes;
  assign rsp.total_blocks   = o_total_blocks;
  assign rsp.total_bytes    = o_total_bytes;
  assign rsp.meta_bytes     = o_meta;

  // calloc size is the full product, otherwise the request itself
  assign size_src = (act == ACT_CALLOC) ? prod_q : {{ADDR_W{1'b0}}, req_q};
  assign size_ok  = (size_src != '0) && (size_src <= (2*ADDR_W)'(MAX_REQUEST));

  // entry payload offset is header offset plus the header, wrapping at 32 bits
  assign rd_payload  = rd_data.start + ADDR_W'(HEADER_BYTES);
  assign brk_payload = break_offset[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);

  // one read issued per cycle, its data compared in the next cycle
  assign scan_issue = (issue_idx < entry_count);
  assign hit_fit    = pend && rd_data.is_free && (rd_data.size >= sz);
  assign hit_find   = pend && (rd_payload == addr_q);
  assign scan_hit   = (state == S_FIT) ? hit_fit : hit_find;
  assign scan_miss  = !pend && !scan_issue;

  assign end_offset = {1'b0, break_offset} + (ADDR_W+2)'(HEADER_BYTES)
                    + (ADDR_W+2)'(sz);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next          = state;
    entry_count_next    = entry_count;
    break_offset_next   = break_offset;
    free_count_next     = free_count;
    free_sum_next       = free_sum;
    size_sum_next       = size_sum;
    pend_next           = pend;
    act_next            = act;
    req_q_next          = req_q;
    cnt_q_next          = cnt_q;
    addr_q_next         = addr_q;
    prod_q_next         = prod_q;
    sz_next             = sz;
    issue_idx_next      = issue_idx;
    pend_idx_next       = pend_idx;
    have_old_next       = have_old;
    old_idx_next        = old_idx;
    old_entry_next      = old_entry;
    res_addr_next       = res_addr;
    status_q_next       = status_q;
    o_addr_next         = o_addr;
    o_status_next       = o_status;
    o_free_blocks_next  = o_free_blocks;
    o_free_bytes_next   = o_free_bytes;
    o_total_blocks_next = o_total_blocks;
    o_total_bytes_next  = o_total_bytes;
    o_meta_next         = o_meta;
    rsp_valid_next      = rsp_valid && !rsp.ready;
    rd_en               = 1'b0;
    rd_addr             = issue_idx[IDX_W-1:0];
    mem_we              = 1'b0;
    mem_wa              = pend_idx;
    mem_wd              = rd_data;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          act_next      = req.action;
          req_q_next    = req.req_size;
          cnt_q_next    = req.elem_count;
          addr_q_next   = req.address;
          have_old_next = 1'b0;
          res_addr_next = '0;
          status_q_next = ST_OK;
          state_next    = (req.action == ACT_CALLOC) ? S_MUL : S_CHECK;
        end
      end

      S_MUL: begin
        // 32 x 32 product, registered before the range check
        prod_q_next = {{ADDR_W{1'b0}}, req_q} * {{ADDR_W{1'b0}}, cnt_q};
        state_next  = S_CHECK;
      end

      S_CHECK: begin
        sz_next        = size_src[SIZE_W-1:0];
        issue_idx_next = '0;
        pend_next      = 1'b0;
        case (act)
          ACT_ALLOC, ACT_CALLOC: begin
            if (size_ok) begin
              state_next = S_FIT;
            end else begin
              status_q_next = ST_BAD_SIZE;
              state_next    = S_DONE;
            end
          end
          ACT_FREE: begin
            state_next = (addr_q == '0) ? S_DONE : S_FIND;
          end
          ACT_REALLOC: begin
            if (!size_ok) begin
              status_q_next = ST_BAD_SIZE;
              state_next    = S_DONE;
            end else if (addr_q == '0) begin
              state_next = S_FIT;
            end else begin
              state_next = S_FIND;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end

      S_FIND, S_FIT: begin
        if (scan_hit) begin
          pend_next = 1'b0;
          if (state == S_FIT) begin
            // take the block whole
            mem_we          = 1'b1;
            mem_wa          = pend_idx;
            mem_wd          = rd_data;
            mem_wd.is_free  = 1'b0;
            free_count_next = free_count - CNT_W'(1);
            free_sum_next   = free_sum - ADDR_W'(rd_data.size);
            res_addr_next   = rd_payload;
            state_next      = have_old ? S_RELEASE : S_DONE;
          end else begin
            old_idx_next   = pend_idx;
            old_entry_next = rd_data;
            if (act == ACT_FREE) begin
              state_next = S_RELEASE;
            end else if (rd_data.size >= sz) begin
              // realloc fits in place
              res_addr_next = addr_q;
              state_next    = S_DONE;
            end else begin
              have_old_next  = 1'b1;
              issue_idx_next = '0;
              state_next     = S_FIT;
            end
          end
        end else if (scan_miss) begin
          if (state == S_FIT) begin
            state_next = S_APPEND;
          end else begin
            status_q_next = ST_UNKNOWN;
            state_next    = S_DONE;
          end
        end else if (scan_issue) begin
          rd_en          = 1'b1;
          rd_addr        = issue_idx[IDX_W-1:0];
          issue_idx_next = issue_idx + CNT_W'(1);
          pend_next      = 1'b1;
          pend_idx_next  = issue_idx[IDX_W-1:0];
        end else begin
          pend_next = 1'b0;
        end
      end

      S_APPEND: begin
        if (entry_count == CNT_W'(MAX_BLOCKS)) begin
          status_q_next = ST_TABLE_FULL;
          state_next    = S_DONE;
        end else if (end_offset > {2'b00, heap_limit}) begin
          status_q_next = ST_EXHAUSTED;
          state_next    = S_DONE;
        end else begin
          mem_we            = 1'b1;
          mem_wa            = entry_count[IDX_W-1:0];
          mem_wd.start      = break_offset[ADDR_W-1:0];
          mem_wd.size       = sz;
          mem_wd.is_free    = 1'b0;
          entry_count_next  = entry_count + CNT_W'(1);
          size_sum_next     = size_sum + ADDR_W'(sz);
          break_offset_next = end_offset[ADDR_W:0];
          res_addr_next     = brk_payload;
          state_next        = have_old ? S_RELEASE : S_DONE;
        end
      end

      S_RELEASE: begin
        // mark free; a block already free keeps its counts
        if (!old_entry.is_free) begin
          mem_we          = 1'b1;
          mem_wa          = old_idx;
          mem_wd          = old_entry;
          mem_wd.is_free  = 1'b1;
          free_count_next = free_count + CNT_W'(1);
          free_sum_next   = free_sum + ADDR_W'(old_entry.size);
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next      = 1'b1;
          o_addr_next         = res_addr;
          o_status_next       = status_q;
          o_free_blocks_next  = free_count;
          o_free_bytes_next   = free_sum;
          o_total_blocks_next = entry_count;
          o_total_bytes_next  = size_sum;
          o_meta_next         = META_W'(32'(entry_count) * HEADER_BYTES);
          state_next          = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      break_offset <= '0;
      free_count   <= '0;
      free_sum     <= '0;
      size_sum     <= '0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
      heap_limit   <= LIMIT_RESET;
    end else begin
      state        <= state_next;
      entry_count  <= entry_count_next;
      break_offset <= break_offset_next;
      free_count   <= free_count_next;
      free_sum     <= free_sum_next;
      size_sum     <= size_sum_next;
      pend         <= pend_next;
      rsp_valid    <= rsp_valid_next;
      if (cfg.valid) begin
        heap_limit <= cfg.data;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    act            <= act_next;
    req_q          <= req_q_next;
    cnt_q          <= cnt_q_next;
    addr_q         <= addr_q_next;
    prod_q         <= prod_q_next;
    sz             <= sz_next;
    issue_idx      <= issue_idx_next;
    pend_idx       <= pend_idx_next;
    have_old       <= have_old_next;
    old_idx        <= old_idx_next;
    old_entry      <= old_entry_next;
    res_addr       <= res_addr_next;
    status_q       <= status_q_next;
    o_addr         <= o_addr_next;
    o_status       <= o_status_next;
    o_free_blocks  <= o_free_blocks_next;
    o_free_bytes   <= o_free_bytes_next;
    o_total_blocks <= o_total_blocks_next;
    o_total_bytes  <= o_total_bytes_next;
    o_meta         <= o_meta_next;
  end

  // a request closes the input until its response is registered
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while a request is in flight");

  // free blocks are a subset of all blocks
  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    free_count <= entry_count)
    else $error("free block count exceeds table size");

  // break never passes a 32-bit heap limit
  a_break_bounded: assert property (@(posedge clk) disable iff (rst)
    !break_offset[ADDR_W])
    else $error("break offset overflowed the 32-bit range");

  // searches never read past the populated part of the table
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND || state == S_FIT) |-> issue_idx <= entry_count)
    else $error("search index past the last block");

endmodule

// ----- sim/first_fit_block_allocator_tb.sv -----
// first_fit_block_allocator_tb: self-checking bench for the first-fit heap block allocator
// needs ffba_pkg, the channel interfaces in ffba_if.sv and the allocator top level

module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  // generous bound on the whole run; its slowest item is a growing realloc on a full table
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 4000;

  // one response beat as seen on the rsp channel
  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        status;
    logic [CNT_W-1:0]  free_blocks;
    logic [ADDR_W-1:0] free_bytes;
    logic [CNT_W-1:0]  total_blocks;
    logic [ADDR_W-1:0] total_bytes;
    logic [META_W-1:0] meta_bytes;
  } alloc_reply_t;

  // shadow heap table plus the queue of responses it predicts
  class heap_scoreboard;
    bit [31:0]      blk_start [MAX_BLOCKS];
    bit [31:0]      blk_size  [MAX_BLOCKS];
    bit             blk_free  [MAX_BLOCKS];
    int unsigned    n_blocks;
    int unsigned    n_free;
    bit [63:0]      brk;
    bit [63:0]      free_total;
    bit [63:0]      size_total;
    bit [31:0]      limit;
    alloc_reply_t   awaited [$];
    int unsigned    errors;
    int unsigned    matched;
    int unsigned    requests;
    int unsigned    status_seen [5];

    function new();
      limit = LIMIT_RESET;
    endfunction

    function bit [31:0] payload(int unsigned i);
      return blk_start[i] + HEADER_BYTES;
    endfunction

    function bit size_valid(bit [63:0] sz);
      return sz != 0 && sz <= MAX_REQUEST;
    endfunction

    // first fit without split, else append at the break
    function status_t grant(bit [63:0] sz, output bit [31:0] addr);
      bit [63:0] top;
      addr = '0;
      for (int unsigned i = 0; i < n_blocks; i++) begin
        if (blk_free[i] && blk_size[i] >= sz) begin
          blk_free[i] = 1'b0;
          n_free--;
          free_total -= blk_size[i];
          addr = payload(i);
          return ST_OK;
        end
      end
      if (n_blocks >= MAX_BLOCKS) return ST_TABLE_FULL;
      top = brk + HEADER_BYTES + sz;
      if (top > limit) return ST_EXHAUSTED;
      blk_start[n_blocks] = brk[31:0];
      blk_size[n_blocks]  = sz[31:0];
      blk_free[n_blocks]  = 1'b0;
      addr = payload(n_blocks);
      n_blocks++;
      size_total += sz;
      brk = top;
      return ST_OK;
    endfunction

    function bit lookup(bit [31:0] a, output int unsigned idx);
      idx = 0;
      for (int unsigned i = 0; i < n_blocks; i++) begin
        if (payload(i) == a) begin
          idx = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void release_block(int unsigned i);
      if (!blk_free[i]) begin
        blk_free[i] = 1'b1;
        n_free++;
        free_total += blk_size[i];
      end
    endfunction

    function void note_request(logic [2:0] act, bit [31:0] sz, bit [31:0] cnt, bit [31:0] a);
      alloc_reply_t want;
      bit [31:0]    granted;
      bit [63:0]    product;
      int unsigned  idx;
      status_t      st;
      granted = '0;
      st = ST_OK;
      case (act)
        ACT_ALLOC: begin
          if (size_valid(sz)) st = grant(sz, granted);
          else st = ST_BAD_SIZE;
        end
        ACT_CALLOC: begin
          product = 64'(sz) * 64'(cnt);
          if (size_valid(product)) st = grant(product, granted);
          else st = ST_BAD_SIZE;
        end
        ACT_FREE: begin
          if (a != 0) begin
            if (lookup(a, idx)) release_block(idx);
            else st = ST_UNKNOWN;
          end
        end
        ACT_REALLOC: begin
          if (!size_valid(sz)) st = ST_BAD_SIZE;
          else if (a == 0) st = grant(sz, granted);
          else if (!lookup(a, idx)) st = ST_UNKNOWN;
          else if (blk_size[idx] >= sz) granted = a;
          else begin
            st = grant(sz, granted);
            if (st == ST_OK) release_block(idx);
          end
        end
        default: ;
      endcase
      want.addr         = granted;
      want.status       = st;
      want.free_blocks  = CNT_W'(n_free);
      want.free_bytes   = free_total[31:0];
      want.total_blocks = CNT_W'(n_blocks);
      want.total_bytes  = size_total[31:0];
      want.meta_bytes   = META_W'(n_blocks * HEADER_BYTES);
      status_seen[st]++;
      requests++;
      awaited.push_back(want);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 100)
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_response(alloc_reply_t got);
      alloc_reply_t want;
      if (awaited.size() == 0) begin
        report("response with nothing pending", got.addr, 0);
        return;
      end
      want = awaited.pop_front();
      if (got.addr !== want.addr) report("result_address", got.addr, want.addr);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.free_blocks !== want.free_blocks)
        report("free_blocks", got.free_blocks, want.free_blocks);
      if (got.free_bytes !== want.free_bytes)
        report("free_bytes", got.free_bytes, want.free_bytes);
      if (got.total_blocks !== want.total_blocks)
        report("total_blocks", got.total_blocks, want.total_blocks);
      if (got.total_bytes !== want.total_bytes)
        report("total_bytes", got.total_bytes, want.total_bytes);
      if (got.meta_bytes !== want.meta_bytes)
        report("meta_bytes", got.meta_bytes, want.meta_bytes);
      matched++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        hold_rsp;
  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned cycles = 0;

  heap_scoreboard sb = new();

  ffba_cfg_if cfg_ch ();
  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();

  first_fit_block_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: a lost or stuck response ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d responses outstanding",
               cycles, sb.awaited.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // response side: check each accepted beat, then pick ready for the next cycle
  // hold_rsp parks ready low so the output register fills and req backs up
  always @(posedge clk) begin : rsp_sink
    alloc_reply_t beat;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      beat.addr         = rsp_ch.result_address;
      beat.status       = rsp_ch.status;
      beat.free_blocks  = rsp_ch.free_blocks;
      beat.free_bytes   = rsp_ch.free_bytes;
      beat.total_blocks = rsp_ch.total_blocks;
      beat.total_bytes  = rsp_ch.total_bytes;
      beat.meta_bytes   = rsp_ch.meta_bytes;
      sb.check_response(beat);
    end
    rsp_ch.ready <= !hold_rsp && !rst && ($urandom_range(99) >= snk_idle);
  end

  // long receiver stall, counted in its own process
  task automatic hold_off(int unsigned n);
    hold_rsp <= 1'b1;
    repeat (n) @(posedge clk);
    hold_rsp <= 1'b0;
  endtask

  // offer one request beat; valid stays up afterwards unless the next call idles
  task automatic send_item(logic [2:0] act, logic [31:0] sz, logic [31:0] cnt,
                           logic [31:0] a);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.req_size   <= sz;
    req_ch.elem_count <= cnt;
    req_ch.address    <= a;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(act, sz, cnt, a);
  endtask

  // stop offering and wait for every predicted response
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // heap_limit write, only issued once drained
  task automatic write_limit(logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    sb.limit = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly small sizes so blocks get reused; wide mode favors appends
  function automatic logic [31:0] rand_size(bit wide);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) begin
      case ($urandom_range(3))
        0: return 0;
        1: return MAX_REQUEST;
        2: return MAX_REQUEST + 1;
        default: return $urandom;
      endcase
    end
    if (r < 8) return $urandom_range(1, MAX_REQUEST);
    if (wide && r < 60) return $urandom_range(65, 4096);
    if (r < 20) return $urandom_range(65, 4096);
    return $urandom_range(1, 64);
  endfunction

  // mostly live payload offsets, some null, some junk or off by one
  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (sb.n_blocks == 0 || r < 8) return 0;
    if (r < 14) return $urandom;
    if (r < 18) begin
      if ($urandom_range(1)) return sb.payload($urandom_range(sb.n_blocks - 1)) + 32'd1;
      return sb.payload($urandom_range(sb.n_blocks - 1)) - 32'd1;
    end
    return sb.payload($urandom_range(sb.n_blocks - 1));
  endfunction

  task automatic random_item(bit wide);
    int unsigned pick;
    logic [2:0]  act;
    logic [31:0] sz;
    logic [31:0] cnt;
    logic [31:0] a;
    pick = $urandom_range(99);
    sz   = rand_size(wide);
    cnt  = $urandom;
    a    = pick_address();
    if (pick < 30) act = ACT_ALLOC;
    else if (pick < 40) begin
      act = ACT_CALLOC;
      if ($urandom_range(9) == 0) sz = $urandom;
      else begin
        sz  = $urandom_range(1, wide ? 512 : 16);
        cnt = $urandom_range(1, 16);
      end
    end
    else if (pick < 62) act = ACT_FREE;
    else if (pick < 82) act = ACT_REALLOC;
    else if (pick < 88) act = 3'($urandom_range(4, 7));
    else begin
      // raw noise on every field
      act = 3'($urandom_range(0, 7));
      sz  = $urandom;
      a   = $urandom;
    end
    send_item(act, sz, cnt, a);
  endtask

  initial begin : stimulus
    int unsigned k;
    rst               = 1'b1;
    hold_rsp          = 1'b0;
    src_idle          = 8;
    snk_idle          = 67;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_QUERY;
    req_ch.req_size   = '0;
    req_ch.elem_count = '0;
    req_ch.address    = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    rsp_ch.ready      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part, reset heap limit (1 MiB), empty table
    send_item(ACT_QUERY, 0, 0, 0);
    send_item(ACT_FREE, 0, 0, 0);                        // free of null
    send_item(ACT_FREE, 0, 0, 32'h0000_1000);            // unknown on empty table
    send_item(ACT_ALLOC, 0, 0, 0);                       // zero size
    send_item(ACT_ALLOC, MAX_REQUEST + 1, 0, 0);         // just over the max
    send_item(ACT_ALLOC, MAX_REQUEST, 0, 0);             // legal but past the limit
    send_item(ACT_ALLOC, 1, 0, 0);                       // block 0
    send_item(ACT_ALLOC, 100, 0, 0);                     // block 1
    send_item(ACT_CALLOC, 8, 0, 0);                      // zero count
    send_item(ACT_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(ACT_CALLOC, 32'h0001_0000, 32'h0001_0000, 0); // product exceeds 32 bits, bad size
    send_item(ACT_CALLOC, 8, 4, 0);                      // block 2
    send_item(ACT_FREE, 0, 0, sb.payload(1));
    send_item(ACT_FREE, 0, 0, sb.payload(1));            // double free
    send_item(ACT_FREE, 0, 0, sb.payload(1) - 32'd1);    // off by one address
    send_item(ACT_ALLOC, 50, 0, 0);                      // reuses block 1 whole
    send_item(ACT_FREE, 0, 0, sb.payload(1));
    send_item(ACT_REALLOC, 30, 0, sb.payload(1));        // fits, free mark kept
    send_item(ACT_REALLOC, 10, 0, 0);                    // realloc of null
    send_item(ACT_REALLOC, 0, 0, sb.payload(0));         // bad size
    send_item(ACT_REALLOC, 4, 0, 32'h0BAD_0000);         // unknown address
    send_item(ACT_REALLOC, 200, 0, sb.payload(0));       // growth, old block freed
    send_item(ACT_REALLOC, MAX_REQUEST, 0, sb.payload(2)); // growth fails, block kept
    send_item(3'd5, 1, 1, 0);                            // unused actions read stats
    send_item(3'd6, 1, 1, 0);
    send_item(3'd7, 1, 1, 0);
    drain();

    // small heap: exhaustion and reuse, sender rarely idle, receiver often
    write_limit(32'd4096);
    repeat (250) random_item(1'b0);
    drain();

    // zero heap: no append fits, so allocations succeed only by reusing blocks; idling swapped
    src_idle = 67;
    snk_idle = 8;
    write_limit(32'd0);
    repeat (100) random_item(1'b0);
    drain();

    // full 32-bit heap, no idling: grow the table to full, with a long
    // receiver stall at the start while requests keep coming
    src_idle = 0;
    snk_idle = 0;
    write_limit(32'hFFFF_FFFF);
    fork
      hold_off(HOLD_CYCLES);
    join_none
    repeat (300) random_item(1'b1);
    for (k = 0; k < 300 && sb.n_blocks < MAX_BLOCKS; k++)
      send_item(ACT_ALLOC, $urandom_range(1, 4096), $urandom, 0);
    drain();

    // mid-range limit on a full table: table full and reuse only
    write_limit(32'h0800_0000);
    repeat (350) random_item(1'b0);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d requests over heap limits 1M, 4K, 0, 4G-1 and 128M, %0d blocks built",
             sb.requests, sb.n_blocks);
    $display("responses checked %0d: ok %0d, bad size %0d, exhausted %0d, table full %0d, unknown %0d",
             sb.matched, sb.status_seen[ST_OK], sb.status_seen[ST_BAD_SIZE],
             sb.status_seen[ST_EXHAUSTED], sb.status_seen[ST_TABLE_FULL],
             sb.status_seen[ST_UNKNOWN]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ffba_pkg.sv
rtl/ffba_if.sv
rtl/first_fit_block_allocator.sv
sim/first_fit_block_allocator_tb.sv
